[sv/rvft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvft_pkg
// shared types and constants of the fifo-track reorder block
// ----------------------------------------------------------------------------
package rvft_pkg;

    // default sizes
    localparam int NUM_TRACKS_DEF  = 4;
    localparam int TRACK_DEPTH_DEF = 8;
    localparam int MAX_ITEMS_DEF   = 64;

    // field widths
    localparam int CAR_W       = 7;
    localparam int ACTION_W    = 2;
    localparam int TRACK_IDX_W = 2;
    localparam int TIU_W       = 3;
    localparam int ICNT_W      = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // results caused by one item, at most
    localparam int MAX_RESULTS  = 33;
    localparam int RESULT_CNT_W = 6;

    // register reset values
    localparam int TIU_RESET  = 4;
    localparam int ICNT_RESET = 64;

    // sequence number ceiling
    localparam logic [CAR_W-1:0] CAR_MAX = 7'h7f;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRACKS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT    = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_DIRECT   = 2'd0,
        ACT_HELD     = 2'd1,
        ACT_RELEASED = 2'd2,
        ACT_NO_FIT   = 2'd3
    } action_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_PLACE  = 6'b000100,
        S_RREAD  = 6'b001000,
        S_RCMP   = 6'b010000,
        S_FLUSH  = 6'b100000
    } state_t;

endpackage

[sv/reorder_via_fifo_tracks.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_via_fifo_tracks
// restores sequence order of numbered items with fifo holding tracks
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one car_number per transfer, with
//   first_of_train set on the first car of a train to empty all tracks,
//   clear the failure flag and restart the expected number at 1
//   output channel (out_valid/out_ready): one to 33 results per input, the
//   final one flagged by last_of_run
//   config channel (cfg_valid/cfg_ready): always ready, index 0 selects
//   tracks_in_use, index 1 item_count; write only while the block is idle
// sequence
//   one item at a time; the input transfer is followed by decide, then
//   placement, which scans the tracks one after another, or release
//   rounds, which skip empty tracks and read the head of each other track
//   from the single track memory before comparing it, and last by flush;
//   results pass a pending stage before the output register
// reset
//   tracks empty, expected number 1, no failure, tracks_in_use 4 and
//   item_count 64 (clamped to the parameters); track memory is not cleared
// stalls
//   a stalled receiver holds the result in the output register; the block
//   waits with its next result and takes a new input once the final result
//   of the item sits in the output register
// ----------------------------------------------------------------------------
module reorder_via_fifo_tracks
    import rvft_pkg::*;
#(
    parameter int NUM_TRACKS  = NUM_TRACKS_DEF,
    parameter int TRACK_DEPTH = TRACK_DEPTH_DEF,
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CAR_W-1:0]       car_number,
    input  logic                   first_of_train,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ACTION_W-1:0]    action,
    output logic [CAR_W-1:0]       moved_car,
    output logic [TRACK_IDX_W-1:0] track_index,
    output logic                   all_done,
    output logic                   last_of_run,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // track select, slot, fill and scan counter widths
    localparam int TW        = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int TCW       = $clog2(NUM_TRACKS + 1);
    localparam int HW        = $clog2(TRACK_DEPTH);
    localparam int FW        = $clog2(TRACK_DEPTH + 1);
    localparam int SW        = FW + 1;
    localparam int AW        = TW + HW;
    localparam int MEM_DEPTH = NUM_TRACKS << HW;

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic [TCW-1:0]           t_reg, t_next;
    logic [RESULT_CNT_W-1:0]  n_reg, n_next;
    logic [CAR_W-1:0]         exp_reg, exp_next;
    logic                     failed_reg, failed_next;
    logic [TIU_W-1:0]         tiu_reg, tiu_next;
    logic [ICNT_W-1:0]        icnt_reg, icnt_next;
    logic [FW-1:0]            fill_reg [NUM_TRACKS];
    logic [FW-1:0]            fill_next [NUM_TRACKS];
    logic [HW-1:0]            head_reg [NUM_TRACKS];
    logic [HW-1:0]            head_next [NUM_TRACKS];
    logic                     pend_valid_reg, pend_valid_next;
    logic                     out_valid_reg, out_valid_next;

    // payload registers
    logic [CAR_W-1:0]         car_reg, car_next;
    logic [CAR_W-1:0]         tail_reg [NUM_TRACKS];
    logic [CAR_W-1:0]         tail_next [NUM_TRACKS];
    action_t                  pend_act_reg, pend_act_next;
    logic [CAR_W-1:0]         pend_car_reg, pend_car_next;
    logic [TRACK_IDX_W-1:0]   pend_trk_reg, pend_trk_next;
    logic                     pend_done_reg, pend_done_next;
    action_t                  out_act_reg, out_act_next;
    logic [CAR_W-1:0]         out_car_reg, out_car_next;
    logic [TRACK_IDX_W-1:0]   out_trk_reg, out_trk_next;
    logic                     out_done_reg, out_done_next;
    logic                     out_last_reg, out_last_next;

    // track memory, one row of slots per track
    logic [CAR_W-1:0]         track_mem [MEM_DEPTH];
    logic [CAR_W-1:0]         rd_data_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [CAR_W-1:0]         mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    logic                     push_ok;
    logic                     gen_ok;
    logic                     in_xfer;
    logic [TW-1:0]            cur_t;
    logic [CAR_W-1:0]         exp_inc;
    logic                     last_track;
    logic [SW-1:0]            slot_sum;
    logic [HW-1:0]            slot_idx;
    logic [HW-1:0]            head_inc;
    logic                     usable;

    // new result into the pending stage, or finish of the item
    logic                     new_res;
    action_t                  new_act;
    logic [CAR_W-1:0]         new_car;
    logic [TRACK_IDX_W-1:0]   new_trk;
    logic                     new_done;
    logic                     finish;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;

    // output register frees when empty or being taken
    assign push_ok = !out_valid_reg || out_ready;
    // pending stage can take a result when empty or it moves on now
    assign gen_ok  = !pend_valid_reg || push_ok;

    assign cur_t      = t_reg[TW-1:0];
    assign exp_inc    = (exp_reg == CAR_MAX) ? exp_reg : exp_reg + 7'd1;
    assign last_track = (t_reg == TCW'(NUM_TRACKS - 1));

    // slot after the tail of the current track, wrapped once
    assign slot_sum = SW'(head_reg[cur_t]) + SW'(fill_reg[cur_t]);
    assign slot_idx = (slot_sum >= SW'(TRACK_DEPTH)) ?
                      HW'(slot_sum - SW'(TRACK_DEPTH)) : HW'(slot_sum);
    assign head_inc = (SW'(head_reg[cur_t]) == SW'(TRACK_DEPTH - 1)) ?
                      '0 : head_reg[cur_t] + HW'(1);

    // empty track, or not full with a smaller tail
    assign usable = (fill_reg[cur_t] == '0) ||
                    ((fill_reg[cur_t] != FW'(TRACK_DEPTH)) && (tail_reg[cur_t] < car_reg));

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        t_next          = t_reg;
        n_next          = n_reg;
        exp_next        = exp_reg;
        failed_next     = failed_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        car_next        = car_reg;
        pend_valid_next = pend_valid_reg;
        pend_act_next   = pend_act_reg;
        pend_car_next   = pend_car_reg;
        pend_trk_next   = pend_trk_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_act_next    = out_act_reg;
        out_car_next    = out_car_reg;
        out_trk_next    = out_trk_reg;
        out_done_next   = out_done_reg;
        out_last_next   = out_last_reg;

        mem_we    = 1'b0;
        mem_waddr = {cur_t, slot_idx};
        mem_wdata = car_reg;
        mem_re    = 1'b0;
        mem_raddr = {cur_t, head_reg[cur_t]};

        new_res  = 1'b0;
        new_act  = ACT_DIRECT;
        new_car  = car_reg;
        new_trk  = '0;
        new_done = (exp_reg > icnt_reg);
        finish   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    car_next = car_number;
                    if (first_of_train)
                    begin
                        for (int i = 0; i < NUM_TRACKS; i++)
                        begin
                            fill_next[i] = '0;
                            head_next[i] = '0;
                        end
                        exp_next    = 7'd1;
                        failed_next = 1'b0;
                    end
                    t_next     = '0;
                    n_next     = '0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (failed_reg)
                begin
                    new_res    = 1'b1;
                    new_act    = ACT_NO_FIT;
                    state_next = S_FLUSH;
                end
                else if (car_reg == exp_reg)
                begin
                    // direct out, then look for heads to release
                    exp_next   = exp_inc;
                    new_res    = 1'b1;
                    new_act    = ACT_DIRECT;
                    new_done   = (exp_inc > icnt_reg);
                    n_next     = RESULT_CNT_W'(1);
                    t_next     = '0;
                    state_next = S_RREAD;
                end
                else
                begin
                    t_next     = '0;
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                if (5'(t_reg) >= 5'(tiu_reg))
                begin
                    // no track fits, failure sticks
                    failed_next = 1'b1;
                    new_res     = 1'b1;
                    new_act     = ACT_NO_FIT;
                    state_next  = S_FLUSH;
                end
                else if (usable)
                begin
                    mem_we           = 1'b1;
                    fill_next[cur_t] = fill_reg[cur_t] + FW'(1);
                    tail_next[cur_t] = car_reg;
                    new_res          = 1'b1;
                    new_act          = ACT_HELD;
                    new_trk          = TRACK_IDX_W'(cur_t);
                    state_next       = S_FLUSH;
                end
                else
                begin
                    t_next = t_reg + TCW'(1);
                end
            end

            S_RREAD:
            begin
                if (fill_reg[cur_t] != '0)
                begin
                    mem_re     = 1'b1;
                    state_next = S_RCMP;
                end
                else if (last_track)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    t_next = t_reg + TCW'(1);
                end
            end

            S_RCMP:
            begin
                if ((rd_data_reg == exp_reg) && (n_reg < RESULT_CNT_W'(MAX_RESULTS)))
                begin
                    // release the head, then rescan from track 0
                    if (gen_ok)
                    begin
                        head_next[cur_t] = head_inc;
                        fill_next[cur_t] = fill_reg[cur_t] - FW'(1);
                        exp_next         = exp_inc;
                        new_res          = 1'b1;
                        new_act          = ACT_RELEASED;
                        new_car          = rd_data_reg;
                        new_trk          = TRACK_IDX_W'(cur_t);
                        new_done         = (exp_inc > icnt_reg);
                        n_next           = n_reg + RESULT_CNT_W'(1);
                        t_next           = '0;
                        state_next       = S_RREAD;
                    end
                end
                else if ((rd_data_reg == exp_reg) || last_track)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    t_next     = t_reg + TCW'(1);
                    state_next = S_RREAD;
                end
            end

            S_FLUSH:
            begin
                if (push_ok)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pending stage holds one result back until it is known whether it
        // is the last one of the item
        if (new_res)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_act_next   = pend_act_reg;
                out_car_next   = pend_car_reg;
                out_trk_next   = pend_trk_reg;
                out_done_next  = pend_done_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_act_next   = new_act;
            pend_car_next   = new_car;
            pend_trk_next   = new_trk;
            pend_done_next  = new_done;
        end

        if (finish)
        begin
            out_valid_next  = 1'b1;
            out_act_next    = pend_act_reg;
            out_car_next    = pend_car_reg;
            out_trk_next    = pend_trk_reg;
            out_done_next   = pend_done_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // configuration writes, values clamped to the parameters
    // ------------------------------------------------------------------------
    always_comb
    begin
        tiu_next  = tiu_reg;
        icnt_next = icnt_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TRACKS_IN_USE:
                begin
                    tiu_next = (5'(cfg_data[TIU_W-1:0]) > 5'(NUM_TRACKS)) ?
                               TIU_W'(NUM_TRACKS) : cfg_data[TIU_W-1:0];
                end
                CFG_ITEM_COUNT:
                begin
                    icnt_next = (11'(cfg_data) > 11'(MAX_ITEMS)) ?
                                ICNT_W'(MAX_ITEMS) : cfg_data;
                end
                default:
                begin
                    tiu_next = tiu_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            t_reg          <= '0;
            n_reg          <= '0;
            exp_reg        <= 7'd1;
            failed_reg     <= 1'b0;
            tiu_reg        <= (NUM_TRACKS < TIU_RESET) ? TIU_W'(NUM_TRACKS) : TIU_W'(TIU_RESET);
            icnt_reg       <= (MAX_ITEMS < ICNT_RESET) ? ICNT_W'(MAX_ITEMS) : ICNT_W'(ICNT_RESET);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_TRACKS; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            t_reg          <= t_next;
            n_reg          <= n_next;
            exp_reg        <= exp_next;
            failed_reg     <= failed_next;
            tiu_reg        <= tiu_next;
            icnt_reg       <= icnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            fill_reg       <= fill_next;
            head_reg       <= head_next;
        end
    end

    // ------------------------------------------------------------------------
    // payload
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        car_reg       <= car_next;
        tail_reg      <= tail_next;
        pend_act_reg  <= pend_act_next;
        pend_car_reg  <= pend_car_next;
        pend_trk_reg  <= pend_trk_next;
        pend_done_reg <= pend_done_next;
        out_act_reg   <= out_act_next;
        out_car_reg   <= out_car_next;
        out_trk_reg   <= out_trk_next;
        out_done_reg  <= out_done_next;
        out_last_reg  <= out_last_next;
    end

    // ------------------------------------------------------------------------
    // track memory: writes only while placing, reads only while releasing,
    // so one item never reads and writes in the same cycle
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            track_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= track_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------------
    assign out_valid   = out_valid_reg;
    assign action      = out_act_reg;
    assign moved_car   = out_car_reg;
    assign track_index = out_trk_reg;
    assign all_done    = out_done_reg;
    assign last_of_run = out_last_reg;

endmodule

[bench/yard_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yard_check_pkg
// predicts the moves of the fifo-track reorder block and checks its results
// ----------------------------------------------------------------------------
package yard_check_pkg;
    import rvft_pkg::*;

    localparam int YARD_TRACKS = NUM_TRACKS_DEF;
    localparam int YARD_DEPTH  = TRACK_DEPTH_DEF;

    typedef logic [$clog2(YARD_DEPTH)-1:0] slot_idx_t;
    typedef logic [$clog2(YARD_DEPTH):0]   slot_cnt_t;

    typedef struct packed {
        action_t                act;
        logic [CAR_W-1:0]       car;
        logic [TRACK_IDX_W-1:0] track;
        logic                   done;
        logic                   last;
    } car_move_t;

    class yard_tracker;
        logic [CAR_W-1:0]  slot [YARD_TRACKS][YARD_DEPTH];
        slot_idx_t         head [YARD_TRACKS];
        slot_cnt_t         fill [YARD_TRACKS];
        logic [CAR_W-1:0]  next_car;
        logic              failed;
        int unsigned       tracks_usable;
        logic [ICNT_W-1:0] train_len;
        car_move_t         due_moves[$];
        int                mismatches;

        function new();
            mismatches    = 0;
            tracks_usable = TIU_RESET;
            train_len     = ICNT_W'(ICNT_RESET);
            clear_yard();
        endfunction

        function void clear_yard();
            for (int t = 0; t < YARD_TRACKS; t++)
            begin
                head[t] = '0;
                fill[t] = '0;
            end
            next_car = CAR_W'(1);
            failed   = 1'b0;
        endfunction

        // expected number stops at the ceiling
        function void step_next();
            if (next_car != CAR_MAX)
                next_car = next_car + 1'b1;
        endfunction

        function void log_move(action_t act, logic [CAR_W-1:0] car,
                               logic [TRACK_IDX_W-1:0] track);
            car_move_t m;
            m.act   = act;
            m.car   = car;
            m.track = track;
            m.done  = (next_car > train_len);
            m.last  = 1'b0;
            due_moves.push_back(m);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            logic [TIU_W-1:0] tiu;
            tiu = data[TIU_W-1:0];
            if (idx == CFG_TRACKS_IN_USE)
                tracks_usable = (tiu > YARD_TRACKS) ? YARD_TRACKS : tiu;
            else if (idx == CFG_ITEM_COUNT)
                train_len = (data > MAX_ITEMS_DEF) ? ICNT_W'(MAX_ITEMS_DEF) : data;
        endfunction

        // works out every move caused by one accepted car
        function void take_car(logic [CAR_W-1:0] car, logic first);
            int               first_idx;
            int               t;
            bit               hit;
            bit               placed;
            slot_cnt_t        f;
            logic [CAR_W-1:0] v;
            car_move_t        m;
            first_idx = due_moves.size();
            if (first)
                clear_yard();
            if (failed)
                log_move(ACT_NO_FIT, car, '0);
            else if (car == next_car)
            begin
                step_next();
                log_move(ACT_DIRECT, car, '0);
                hit = 1'b1;
                while (hit && due_moves.size() - first_idx < MAX_RESULTS)
                begin
                    hit = 1'b0;
                    for (t = 0; t < YARD_TRACKS && !hit; t++)
                    begin
                        if (fill[t] != 0 && slot[t][head[t]] == next_car)
                        begin
                            v       = slot[t][head[t]];
                            head[t] = head[t] + 1'b1;
                            fill[t] = fill[t] - 1'b1;
                            step_next();
                            log_move(ACT_RELEASED, v, TRACK_IDX_W'(t));
                            hit = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                placed = 1'b0;
                for (t = 0; t < YARD_TRACKS && t < tracks_usable && !placed; t++)
                begin
                    f = fill[t];
                    if (f == 0 ||
                        (f < YARD_DEPTH && slot[t][slot_idx_t'(head[t] + f - 1'b1)] < car))
                    begin
                        slot[t][slot_idx_t'(head[t] + f)] = car;
                        fill[t] = f + 1'b1;
                        log_move(ACT_HELD, car, TRACK_IDX_W'(t));
                        placed = 1'b1;
                    end
                end
                if (!placed)
                begin
                    failed = 1'b1;
                    log_move(ACT_NO_FIT, car, '0);
                end
            end
            m = due_moves.pop_back();
            m.last = 1'b1;
            due_moves.push_back(m);
        endfunction

        function void match_move(car_move_t got);
            car_move_t want;
            if (due_moves.size() == 0)
            begin
                $display("%0t: unexpected result act %0d car %0d track %0d done %0b last %0b",
                         $time, got.act, got.car, got.track, got.done, got.last);
                mismatches++;
                return;
            end
            want = due_moves.pop_front();
            if (got.act !== want.act || got.car !== want.car || got.track !== want.track ||
                got.done !== want.done || got.last !== want.last)
            begin
                $display("%0t: expected act %0d car %0d track %0d done %0b last %0b",
                         $time, want.act, want.car, want.track, want.done, want.last);
                $display("%0t:   actual act %0d car %0d track %0d done %0b last %0b",
                         $time, got.act, got.car, got.track, got.done, got.last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the fifo-track reorder block against a move predictor
// ----------------------------------------------------------------------------
// every accepted car is run through the predictor, which queues the moves it
// should cause; every result transfer is compared with the oldest queued move
// a short directed run covers held, direct, released and no-fit moves, a full
// track, releases from tracks outside the search range, stale and repeated
// numbers and the failed state; random trains follow under several register
// settings and idle patterns, including a long receiver hold-off and a train
// that drives the expected number up to its ceiling
// ----------------------------------------------------------------------------
module testbench;
    import rvft_pkg::*;
    import yard_check_pkg::*;

    localparam int STALL_LIMIT   = 5000;  // cycles with no transfer at all
    localparam int SETTLE_CYCLES = 20;    // quiet time once all results are in
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off

    typedef enum logic [2:0] {
        TRAIN_PAIRS,   // adjacent swaps only, sortable with at least one track
        TRAIN_NEAR,    // short-range swaps
        TRAIN_FULL,    // full shuffle
        TRAIN_BROKEN,  // short-range swaps with one car spoiled
        TRAIN_NOISE    // random numbers, random train starts
    } train_style_t;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;

    logic                   in_valid       = 1'b0;
    logic                   in_ready;
    logic [CAR_W-1:0]       car_number     = '0;
    logic                   first_of_train = 1'b0;

    logic                   out_valid;
    logic                   out_ready      = 1'b0;
    logic [ACTION_W-1:0]    action;
    logic [CAR_W-1:0]       moved_car;
    logic [TRACK_IDX_W-1:0] track_index;
    logic                   all_done;
    logic                   last_of_run;

    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;

    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          quiet_cycles = 0;
    int          cars_sent    = 0;
    yard_tracker yard;

    reorder_via_fifo_tracks dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .car_number     (car_number),
        .first_of_train (first_of_train),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .action         (action),
        .moved_car      (moved_car),
        .track_index    (track_index),
        .all_done       (all_done),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver: a requested hold-off is counted here, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    // every result transfer goes to the checker
    always @(posedge clk)
    begin : result_monitor
        car_move_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.act   = action_t'(action);
            seen.car   = moved_car;
            seen.track = track_index;
            seen.done  = all_done;
            seen.last  = last_of_run;
            yard.match_move(seen);
        end
    end

    // watchdog: any transfer on any channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // one car transfer; an optional idle gap first, valid held until taken
    task automatic send_car(input logic [CAR_W-1:0] car, input logic first);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && gap < 60 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        car_number     <= car;
        first_of_train <= first;
        do
            @(posedge clk);
        while (!in_ready);
        yard.take_car(car, first);
        cars_sent++;
    endtask

    // stop offering and wait until every predicted move has come out
    task automatic drain_yard();
        in_valid <= 1'b0;
        while (yard.due_moves.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers in back-to-back transfers; only called while idle
    task automatic program_yard(input logic [CFG_DATA_W-1:0] tiu,
                                input logic [CFG_DATA_W-1:0] icnt);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TRACKS_IN_USE;
        cfg_data  <= tiu;
        do
            @(posedge clk);
        while (!cfg_ready);
        yard.set_register(CFG_TRACKS_IN_USE, tiu);
        cfg_index <= CFG_ITEM_COUNT;
        cfg_data  <= icnt;
        do
            @(posedge clk);
        while (!cfg_ready);
        yard.set_register(CFG_ITEM_COUNT, icnt);
        cfg_valid <= 1'b0;
    endtask

    // mostly short trains, a few long ones
    function automatic int train_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(2, 12);
        else if (pick < 95)
            return $urandom_range(13, 40);
        return $urandom_range(41, 64);
    endfunction

    task automatic run_train(input int n, input train_style_t style);
        logic [CAR_W-1:0] order[$];
        logic [CAR_W-1:0] tmp;
        int               i;
        int               j;
        for (i = 1; i <= n; i++)
            order.push_back(CAR_W'(i));
        if (style == TRAIN_PAIRS)
        begin
            for (i = 0; i + 1 < n; i += 2)
                if ($urandom_range(2) == 0)
                begin
                    tmp          = order[i];
                    order[i]     = order[i + 1];
                    order[i + 1] = tmp;
                end
        end
        else if (style == TRAIN_FULL)
        begin
            for (i = n - 1; i > 0; i--)
            begin
                j        = $urandom_range(i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        end
        else if (style != TRAIN_NOISE)
        begin
            for (i = 0; i + 1 < n; i++)
                if ($urandom_range(2) == 0)
                begin
                    j        = i + $urandom_range(1, (n - 1 - i < 3) ? n - 1 - i : 3);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
        end
        // spoil one car: a stray number, a lost car or a repeat
        if (style == TRAIN_BROKEN)
        begin
            j = $urandom_range(n - 1);
            case ($urandom_range(2))
                0:       order[j] = CAR_W'($urandom_range(127));
                1:       order.delete(j);
                default: order.insert(j, order[$urandom_range(n - 1)]);
            endcase
        end
        if (style == TRAIN_NOISE)
            foreach (order[k])
                order[k] = CAR_W'($urandom_range(127));
        foreach (order[k])
            send_car(order[k], (style == TRAIN_NOISE) ? ($urandom_range(7) == 0) : (k == 0));
    endtask

    // one register setting and idle pattern, random trains until the budget is used
    task automatic run_phase(input logic [CFG_DATA_W-1:0] tiu, input logic [CFG_DATA_W-1:0] icnt,
                             input int tx_pct, input int rx_pct, input int budget);
        int sent_before;
        int pick;
        program_yard(tiu, icnt);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent_before  = cars_sent;
        while (cars_sent - sent_before < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                run_train(train_size(), TRAIN_PAIRS);
            else if (pick < 55)
                run_train(train_size(), TRAIN_NEAR);
            else if (pick < 72)
                run_train($urandom_range(2, 10), TRAIN_FULL);
            else if (pick < 88)
                run_train($urandom_range(3, 16), TRAIN_BROKEN);
            else
                run_train($urandom_range(1, 6), TRAIN_NOISE);
        end
        drain_yard();
    endtask

    initial
    begin
        yard = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // releases reach tracks outside the search range; done rises mid-run
        program_yard(4, 3);
        send_car(4, 1'b1);
        send_car(3, 1'b0);
        send_car(2, 1'b0);
        drain_yard();
        program_yard(1, 3);
        send_car(1, 1'b0);
        send_car(9, 1'b0);
        send_car(8, 1'b0);   // no track fits with one track in use
        send_car(6, 1'b0);   // ignored while failed

        // two tracks: chained releases, stale and repeated numbers, top number
        drain_yard();
        program_yard(2, 8);
        send_car(5, 1'b1);
        send_car(3, 1'b0);
        send_car(4, 1'b0);
        send_car(1, 1'b0);
        send_car(2, 1'b0);
        send_car(0, 1'b0);
        send_car(0, 1'b0);
        send_car(127, 1'b0);
        send_car(3, 1'b0);
        send_car(2, 1'b0);

        // track 0 fills up, the next car moves on to track 1
        drain_yard();
        program_yard(4, 64);
        send_car(10, 1'b1);
        for (int c = 11; c <= 18; c++)
            send_car(CAR_W'(c), 1'b0);
        drain_yard();

        // receiver holds off while the sender keeps offering, then a full pause
        hold_request = HOLD_CYCLES;
        run_train(24, TRAIN_NEAR);
        drain_yard();

        // long train of adjacent swaps pushes the expected number to its ceiling
        run_train(127, TRAIN_PAIRS);
        send_car(127, 1'b0);
        send_car(127, 1'b0);
        drain_yard();

        run_phase(3,     20,  81, 0,  28);
        run_phase(7,     127, 0,  81, 28);
        run_phase(2,     1,   25, 25, 28);
        run_phase(0,     0,   0,  0,  20);
        run_phase(7'h7d, 40,  81, 0,  28);
        run_phase(1,     64,  0,  81, 28);
        run_phase(6,     33,  25, 25, 28);

        if (yard.mismatches == 0 && yard.due_moves.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
sv/rvft_pkg.sv
sv/reorder_via_fifo_tracks.sv
bench/yard_check_pkg.sv
bench/testbench.sv
